### rtl/lpht_pkg.sv
// shared types and defaults for the linear probing hash table
package lpht_pkg;

   localparam int TABLE_SIZE_DEF    = 64;
   localparam int KEY_MAX_BYTES_DEF = 8;

   localparam int KEY_PORT_BYTES = 8;
   localparam int KEY_PORT_W     = 8 * KEY_PORT_BYTES;
   localparam int LEN_W          = 4;
   localparam int VALUE_W        = 32;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_UPDATED   = 3'd1,
      STATUS_FOUND     = 3'd2,
      STATUS_REMOVED   = 3'd3,
      STATUS_NOT_FOUND = 3'd4,
      STATUS_FULL      = 3'd5
   } status_type;

endpackage

### rtl/linear_probe_hash_table.sv
// open addressing key/value table with linear probing and tombstones
//
//  channel  direction  tdata (lowest bit up)                           tuser
//  req      in         key_bytes 64, key_length 4, new_value 32, pad 4  opcode 2
//  rsp      out        found_value 32                                   status 3
//
// one item passes an accept step, one hash step per key byte, a registered
// memory read and then a compare per probed slot, and a result step; an
// unused opcode goes from accept straight to the result step. the hash
// step is a single mul-by-31, add and reduce unit shared over all bytes.
// after reset a clearing pass sweeps the slot marks while req_tready stays low.
// the next item is accepted while a result still waits on rsp.
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
   parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // key_bytes, key_length, new_value, zero pad
   input  logic [1:0]            req_tuser,  // opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // found_value
   output logic [2:0]            rsp_tuser   // status
);

   localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int KW = 8 * KEY_MAX_BYTES;
   // quotient bits of (acc*31 + byte) / TABLE_SIZE
   localparam int HQ = $clog2(32 + 256 / TABLE_SIZE + 1);
   localparam int RW = IW + HQ + 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_ADDR,
      S_CHECK,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_USED  = 2'd1,
      MARK_TOMB  = 2'd2
   } mark_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [LEN_W-1:0]   len;
      logic [KW-1:0]      key;
   } slot_type;

   function automatic logic [IW-1:0] hash_step(input logic [IW-1:0] acc,
                                               input logic [7:0] b);
      logic [RW-1:0] t;
      int k;
      t = (RW'(acc) << 5) - RW'(acc) + RW'(b);
      for (k = HQ - 1; k >= 0; k--) begin
         if (t >= (RW'(TABLE_SIZE) << k)) begin
            t = t - (RW'(TABLE_SIZE) << k);
         end
      end
      return IW'(t);
   endfunction

   state_type          state_ff, state_in;
   opcode_type         op_ff, op_in;
   logic [KW-1:0]      key_ff, key_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [LEN_W-1:0]   byte_ff, byte_in;
   logic [IW-1:0]      probe_ff, probe_in;
   logic               have_free_ff, have_free_in;
   logic [IW-1:0]      free_ff, free_in;
   status_type         res_status_ff, res_status_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   mark_type mark_mem [TABLE_SIZE];
   slot_type slot_mem [TABLE_SIZE];
   mark_type mark_rd_ff;
   slot_type slot_rd_ff;

   logic     mark_we;
   logic [IW-1:0] mark_waddr;
   mark_type mark_wdata;
   logic     slot_we;
   logic [IW-1:0] slot_waddr;
   slot_type slot_wdata;

   logic            accept;
   logic [LEN_W-1:0] len_sat;
   logic [7:0]      byte_val;

   assign accept     = req_tvalid && (state_ff == S_IDLE);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign len_sat  = (req_tdata[67:64] > LEN_W'(KEY_MAX_BYTES)) ?
                     LEN_W'(KEY_MAX_BYTES) : req_tdata[67:64];
   assign byte_val = 8'(key_ff >> {byte_ff, 3'b000});

   always_comb begin
      logic          hit;
      logic          done;
      logic          fs_valid;
      logic [IW-1:0] fs_idx;
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      len_in        = len_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      byte_in       = byte_ff;
      probe_in      = probe_ff;
      have_free_in  = have_free_ff;
      free_in       = free_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      mark_we       = 1'b0;
      mark_waddr    = idx_ff;
      mark_wdata    = MARK_EMPTY;
      slot_we       = 1'b0;
      slot_waddr    = idx_ff;
      slot_wdata    = '{value: val_ff, len: len_ff, key: key_ff};
      hit           = 1'b0;
      done          = 1'b0;
      fs_valid      = 1'b0;
      fs_idx        = idx_ff;

      case (state_ff)
         S_CLEAR: begin
            mark_we = 1'b1;
            if (idx_ff == IW'(TABLE_SIZE - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in        = opcode_type'(req_tuser);
               len_in       = len_sat;
               val_in       = req_tdata[99:68];
               idx_in       = '0;
               byte_in      = '0;
               probe_in     = '0;
               have_free_in = 1'b0;
               for (int i = 0; i < KEY_MAX_BYTES; i++) begin
                  key_in[8*i +: 8] = (LEN_W'(i) < len_sat) ? req_tdata[8*i +: 8] : 8'd0;
               end
               if (opcode_type'(req_tuser) == OP_NONE) begin
                  res_status_in = STATUS_NOT_FOUND;
                  res_value_in  = '0;
                  state_in      = S_FINISH;
               end else if (len_sat == '0) begin
                  state_in = S_ADDR;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            idx_in  = hash_step(idx_ff, byte_val);
            byte_in = byte_ff + 1'b1;
            if (byte_ff + 1'b1 == len_ff) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            // slot data for idx_ff shows up in the read registers next cycle
            state_in = S_CHECK;
         end
         S_CHECK: begin
            case (mark_rd_ff)
               MARK_EMPTY: begin
                  done = 1'b1;
               end
               MARK_TOMB: begin
                  if (!have_free_ff) begin
                     have_free_in = 1'b1;
                     free_in      = idx_ff;
                  end
               end
               MARK_USED: begin
                  if (slot_rd_ff.len == len_ff && slot_rd_ff.key == key_ff) begin
                     hit  = 1'b1;
                     done = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            if (!done) begin
               if (probe_ff == IW'(TABLE_SIZE - 1)) begin
                  done = 1'b1;
               end else begin
                  probe_in = probe_ff + 1'b1;
                  idx_in   = (idx_ff == IW'(TABLE_SIZE - 1)) ? '0 : idx_ff + 1'b1;
                  state_in = S_ADDR;
               end
            end
            // first free slot seen along the chain, this one included
            if (have_free_ff) begin
               fs_valid = 1'b1;
               fs_idx   = free_ff;
            end else if (mark_rd_ff == MARK_EMPTY || mark_rd_ff == MARK_TOMB) begin
               fs_valid = 1'b1;
               fs_idx   = idx_ff;
            end
            if (done) begin
               state_in      = S_FINISH;
               res_status_in = STATUS_NOT_FOUND;
               res_value_in  = '0;
               case (op_ff)
                  OP_INSERT: begin
                     if (hit) begin
                        slot_we       = 1'b1;
                        slot_waddr    = idx_ff;
                        res_status_in = STATUS_UPDATED;
                     end else if (fs_valid) begin
                        slot_we       = 1'b1;
                        slot_waddr    = fs_idx;
                        mark_we       = 1'b1;
                        mark_waddr    = fs_idx;
                        mark_wdata    = MARK_USED;
                        res_status_in = STATUS_INSERTED;
                     end else begin
                        res_status_in = STATUS_FULL;
                     end
                  end
                  OP_SEARCH: begin
                     if (hit) begin
                        res_status_in = STATUS_FOUND;
                        res_value_in  = slot_rd_ff.value;
                     end
                  end
                  OP_REMOVE: begin
                     if (hit) begin
                        mark_we       = 1'b1;
                        mark_waddr    = idx_ff;
                        mark_wdata    = MARK_TOMB;
                        res_status_in = STATUS_REMOVED;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         idx_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      len_ff        <= len_in;
      val_ff        <= val_in;
      byte_ff       <= byte_in;
      probe_ff      <= probe_in;
      have_free_ff  <= have_free_in;
      free_ff       <= free_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      mark_rd_ff <= mark_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[idx_ff];
   end

endmodule

### rtl/lpht_checker.sv
// port-level checks for the hash table, bound to the top level
module lpht_assertions
   import lpht_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [1:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [2:0]            rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // only found carries a value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_FOUND |-> rsp_tdata == '0)
      else $error("nonzero value without found status");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while busy");

   // the mark clearing pass keeps the input closed
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("ready during clearing pass");

endmodule

bind linear_probe_hash_table lpht_assertions u_lpht_assertions (.*);

### verif/lpht_checker.sv
// scoreboard for the hash table: tracks table contents and checks every answer
module lpht_checker
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
   parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // key_bytes, key_length, new_value, zero pad
   input  logic [1:0]            req_tuser,  // opcode
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // found_value
   input  logic [2:0]            rsp_tuser,  // status
   output int                    error_count,
   output int                    pending_count,
   output int                    answer_count,
   output int                    found_count,
   output int                    removed_count,
   output int                    full_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_USED  = 2'd1,
      SLOT_TOMB  = 2'd2
   } slot_state_type;

   typedef struct packed {
      status_type           status;
      logic [VALUE_W-1:0]   value;
   } answer_type;

   logic [KEY_PORT_W-1:0] slot_key   [TABLE_SIZE];
   logic [LEN_W-1:0]      slot_len   [TABLE_SIZE];
   logic [VALUE_W-1:0]    slot_value [TABLE_SIZE];
   slot_state_type        slot_state [TABLE_SIZE];
   int                    used_slots;

   answer_type awaited_answers[$];
   int errors = 0, answers = 0, founds = 0, removes = 0, fulls = 0;

   // runs one operation against the shadow table and returns its answer
   function automatic answer_type apply_op(opcode_type op, logic [KEY_PORT_W-1:0] key_in,
                                           logic [LEN_W-1:0] len_in,
                                           logic [VALUE_W-1:0] new_value);
      logic [KEY_PORT_W-1:0] key;
      int                    len;
      int unsigned           idx;
      int unsigned           free_idx;
      bit                    have_free;
      bit                    hit;
      answer_type            ans;

      ans.status = STATUS_NOT_FOUND;
      ans.value  = '0;
      len = (len_in > KEY_MAX_BYTES) ? KEY_MAX_BYTES : int'(len_in);
      key = key_in;
      if (len < KEY_PORT_BYTES)
         key &= (64'd1 << (8 * len)) - 64'd1;
      if (op == OP_NONE)
         return ans;

      idx = 0;
      for (int i = 0; i < len; i++)
         idx = (idx * 31 + key[8*i +: 8]) % TABLE_SIZE;

      have_free = 1'b0;
      hit       = 1'b0;
      free_idx  = 0;
      for (int n = 0; n < TABLE_SIZE; n++) begin
         if (slot_state[idx] == SLOT_EMPTY) begin
            if (!have_free) begin
               have_free = 1'b1;
               free_idx  = idx;
            end
            break;
         end
         if (slot_state[idx] == SLOT_TOMB) begin
            if (!have_free) begin
               have_free = 1'b1;
               free_idx  = idx;
            end
         end else if (slot_len[idx] == len && slot_key[idx] == key) begin
            hit = 1'b1;
            break;
         end
         idx = (idx + 1) % TABLE_SIZE;
      end

      case (op)
         OP_INSERT: begin
            if (hit) begin
               slot_value[idx] = new_value;
               ans.status = STATUS_UPDATED;
            end else if (have_free) begin
               slot_key[free_idx]   = key;
               slot_len[free_idx]   = LEN_W'(len);
               slot_value[free_idx] = new_value;
               slot_state[free_idx] = SLOT_USED;
               used_slots++;
               ans.status = STATUS_INSERTED;
            end else begin
               ans.status = STATUS_FULL;
            end
         end
         OP_SEARCH: begin
            if (hit) begin
               ans.status = STATUS_FOUND;
               ans.value  = slot_value[idx];
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               slot_state[idx] = SLOT_TOMB;
               slot_key[idx]   = '0;
               slot_len[idx]   = '0;
               slot_value[idx] = '0;
               if (used_slots > 0)
                  used_slots--;
               ans.status = STATUS_REMOVED;
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++)
            slot_state[i] = SLOT_EMPTY;
         used_slots = 0;
         awaited_answers.delete();
      end else begin
         // results first, so an unexpected one is not matched to this cycle's item
         if (rsp_tvalid && rsp_tready) begin
            answers++;
            if (awaited_answers.size() == 0) begin
               errors++;
               $error("unexpected result: status %0d found_value %0d", rsp_tuser,
                      $signed(rsp_tdata));
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_tuser !== want.status) begin
                  errors++;
                  $error("status mismatch: expected %0d, actual %0d", want.status, rsp_tuser);
               end
               if (rsp_tdata !== want.value) begin
                  errors++;
                  $error("found_value mismatch: expected %0d, actual %0d",
                         $signed(want.value), $signed(rsp_tdata));
               end
               case (want.status)
                  STATUS_FOUND:   founds++;
                  STATUS_REMOVED: removes++;
                  STATUS_FULL:    fulls++;
                  default: ;
               endcase
            end
         end
         if (req_tvalid && req_tready)
            awaited_answers.push_back(apply_op(opcode_type'(req_tuser),
                                               req_tdata[KEY_PORT_W-1:0],
                                               req_tdata[KEY_PORT_W +: LEN_W],
                                               req_tdata[KEY_PORT_W+LEN_W +: VALUE_W]));
      end
      error_count   <= errors;
      pending_count <= awaited_answers.size();
      answer_count  <= answers;
      found_count   <= founds;
      removed_count <= removes;
      full_count    <= fulls;
   end

endmodule

### verif/tb_linear_probe_hash_table.sv
// top of the hash table testbench: clock, reset, request traffic and verdict
module tb_linear_probe_hash_table;
   import lpht_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_SIZE    = 120;
   localparam int LIMIT_CYCLES = 5_000_000;
   localparam int ROUNDS       = 4;

   localparam int READY_ALWAYS  = 0;
   localparam int READY_RANDOM  = 1;
   localparam int READY_PATTERN = 2;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // key_bytes, key_length, new_value, zero pad
   logic [1:0]            req_tuser  = OP_NONE;  // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // found_value
   logic [2:0]            rsp_tuser;  // status

   int error_count, pending_count, answer_count, found_count, removed_count, full_count;
   int sent_items  = 0;
   int burst_left  = 0;
   int cycle_count = 0;

   logic [KEY_PORT_W-1:0] pool_key [POOL_SIZE];
   int                    pool_len [POOL_SIZE];

   int         ready_mode = READY_ALWAYS;
   int         mode_left  = 0;
   logic [7:0] stall_bits = 8'hff;

   linear_probe_hash_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lpht_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_count (pending_count),
      .answer_count  (answer_count),
      .found_count   (found_count),
      .removed_count (removed_count),
      .full_count    (full_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver backpressure: always ready, coin flips, or a rotating stall word
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = $urandom_range(READY_ALWAYS, READY_PATTERN);
         mode_left  = $urandom_range(50, 300);
         stall_bits = 8'($urandom);
      end else begin
         mode_left--;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         default: begin
            rsp_tready <= stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[7:1]};
         end
      endcase
   end

   task automatic send_item(opcode_type op, logic [KEY_PORT_W-1:0] key, logic [LEN_W-1:0] len,
                            logic [VALUE_W-1:0] new_value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, new_value, len, key};
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   // hold the sender until the table has answered everything
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // mostly pool keys with junk above the length, some stray keys and unused opcodes
   task automatic random_item(int insert_pct, int search_pct);
      int                    pick;
      int                    k;
      logic [KEY_PORT_W-1:0] keep;
      logic [KEY_PORT_W-1:0] key;
      logic [LEN_W-1:0]      len;
      logic [VALUE_W-1:0]    new_value;
      opcode_type            op;
      new_value = $urandom;
      if ($urandom_range(0, 15) == 0)
         new_value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         op  = (pick < 3) ? OP_NONE : opcode_type'($urandom_range(0, 2));
         key = {$urandom, $urandom};
         len = LEN_W'($urandom_range(0, 15));
      end else begin
         k    = $urandom_range(0, POOL_SIZE - 1);
         pick = $urandom_range(0, 99);
         op   = (pick < insert_pct) ? OP_INSERT :
                (pick < insert_pct + search_pct) ? OP_SEARCH : OP_REMOVE;
         len  = LEN_W'(pool_len[k]);
         if (pool_len[k] == KEY_PORT_BYTES && $urandom_range(0, 3) == 0)
            len = LEN_W'($urandom_range(9, 15));
         keep = (pool_len[k] == KEY_PORT_BYTES) ? '1 : (64'd1 << (8 * pool_len[k])) - 64'd1;
         key  = (pool_key[k] & keep) | ({$urandom, $urandom} & ~keep);
      end
      send_item(op, key, len, new_value);
   endtask

   initial begin
      // first keys are one byte long and pile up in two neighboring buckets
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i < 8) begin
            pool_len[i] = 1;
            pool_key[i] = 64'(8'h05 + (i % 2) + 8'h40 * (i / 2));
         end else begin
            pool_len[i] = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(1, 8);
            pool_key[i] = {$urandom, $urandom};
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty key, saturated length, collisions, tombstones, unused opcode
      send_item(OP_SEARCH, 64'h0, 4'd0, 32'h0);
      send_item(OP_INSERT, 64'hffff_ffff_ffff_ffff, 4'd0, 32'h7fff_ffff);
      send_item(OP_SEARCH, 64'h0, 4'd0, 32'hffff_ffff);
      send_item(OP_INSERT, 64'hffff_ffff_ffff_ffff, 4'd15, 32'h8000_0000);
      send_item(OP_SEARCH, 64'hffff_ffff_ffff_ffff, 4'd8, 32'h0);
      send_item(OP_INSERT, 64'h5555_5555_5555_5501, 4'd1, 32'h1);
      send_item(OP_INSERT, 64'h0000_0000_0000_0041, 4'd1, 32'h2);
      send_item(OP_INSERT, 64'h0000_0000_0000_0001, 4'd2, 32'h3);
      send_item(OP_SEARCH, 64'haaaa_aaaa_aaaa_aa01, 4'd1, 32'h0);
      send_item(OP_REMOVE, 64'h0000_0000_0000_0001, 4'd1, 32'h0);
      send_item(OP_SEARCH, 64'h1234_5678_9abc_de41, 4'd1, 32'h0);
      send_item(OP_INSERT, 64'h0000_0000_0000_0081, 4'd1, 32'h4);
      send_item(OP_INSERT, 64'h0000_0000_0000_0041, 4'd1, 32'h5);
      send_item(OP_SEARCH, 64'hffff_ffff_ffff_0001, 4'd2, 32'h0);
      send_item(OP_REMOVE, 64'h0000_0000_0000_0001, 4'd1, 32'h0);
      send_item(OP_NONE,   64'h0000_0000_0000_0041, 4'd1, 32'hffff_ffff);
      send_item(OP_REMOVE, 64'h0000_0000_0000_0000, 4'd0, 32'h0);
      send_item(OP_SEARCH, 64'h0000_0000_0000_0000, 4'd0, 32'h0);
      send_item(OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 4'd8, 32'h0);
      send_item(OP_SEARCH, 64'h5555_5555_5555_5555, 4'd8, 32'h0);
      send_item(OP_REMOVE, 64'hffff_ffff_ffff_ffff, 4'd9, 32'h0);
      wait_drained();

      // fill with mostly inserts toward a full table, then thin it out and leave tombstones
      for (int r = 0; r < ROUNDS; r++) begin
         repeat (170) random_item(80, 12);
         wait_drained();
         repeat (90) random_item(15, 35);
         wait_drained();
      end

      repeat (200) @(posedge clock);
      $display("sent %0d items over %0d fill and drain rounds, %0d results checked",
               sent_items, ROUNDS, answer_count);
      $display("answers seen: %0d found, %0d removed, %0d table full",
               found_count, removed_count, full_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/lpht_pkg.sv
rtl/linear_probe_hash_table.sv
rtl/lpht_checker.sv
verif/lpht_checker.sv
verif/tb_linear_probe_hash_table.sv
